// ----- design/tcc_pkg.sv -----
// Shared types and constants for the text console cursor controller.
// No dependencies; imported by tcc_mod, tcc_step and the top level.
`timescale 1ns / 1ps

package tcc_pkg;

    typedef enum logic [2:0] {
        OP_ERASE  = 3'd0,
        OP_GLYPH  = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_SCROLL = 3'd3,
        OP_CURSOR = 3'd4
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] column;
        logic [6:0] row;
        logic [7:0] glyph;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [7:0] column;
        logic [6:0] row;
    } pos_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

    localparam int unsigned MAX_CMDS = 4;

    localparam logic [7:0] CH_NUL       = 8'd0;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;

    // register select is the word address bit
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd30;

endpackage

// ----- design/tcc_mod.sv -----
// Restoring remainder unit: dividend % divisor, one quotient bit per cycle.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_mod (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [7:0]            dividend,
    input  logic [7:0]            divisor,
    output tcc_pkg::mod_stat_t    status,
    output logic [7:0]            rem
);
    import tcc_pkg::*;

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] step_reg, step_next;
    logic [7:0] x_reg;
    logic [7:0] d_reg;
    logic [7:0] rem_reg, rem_next;
    logic [8:0] trial;

    always_comb begin
        trial    = {rem_reg, x_reg[7]};
        rem_next = (trial >= {1'b0, d_reg}) ? 8'(trial - {1'b0, d_reg}) : trial[7:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = 3'd0;
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= 8'd0;
        end else if (busy_reg) begin
            x_reg   <= {x_reg[6:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign status = '{busy: busy_reg, done: done_reg};
    assign rem    = rem_reg;

endmodule

// ----- design/tcc_step.sv -----
// Command builder: turns one character and the cursor state into the ordered
// drawing commands and the next cursor cell. Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_step #(
    parameter int unsigned TAB_WIDTH = 8
) (
    input  logic [7:0]                               char_code,
    input  tcc_pkg::pos_t                            cur,
    input  tcc_pkg::pos_t                            shown,
    input  logic [7:0]                               bs_column,
    input  logic [7:0]                               ncol,
    input  logic [6:0]                               nrow,
    output tcc_pkg::cmd_t [tcc_pkg::MAX_CMDS-1:0]    cmds,
    output logic [2:0]                               count,
    output tcc_pkg::pos_t                            nxt
);
    import tcc_pkg::*;

    // floor(col / TAB_WIDTH) via reciprocal; exact for 8-bit col and 2 <= width <= 32
    localparam int unsigned TabRecip = 65536 / TAB_WIDTH + 1;

    logic [23:0] tab_prod;
    logic [7:0]  tab_q;
    logic [15:0] tab_stop;
    logic [7:0]  px;
    logic [6:0]  py;
    logic [8:0]  col_a, col_w;
    logic [7:0]  row_a, row_w, row_s;
    logic        mid_valid;
    cmd_t        mid;
    logic        scroll;
    logic [1:0]  idx;

    always_comb begin
        tab_prod = cur.column * TabRecip[15:0];
        tab_q    = tab_prod[23:16];
        tab_stop = 16'(({8'd0, tab_q} + 16'd1) * 16'(TAB_WIDTH));
        // backspace target: at a line start, the last column of the row above
        px = (cur.column == 8'd0) ? ncol - 8'd1 : bs_column;
        py = (cur.column == 8'd0) ? cur.row - 7'd1 : cur.row;
    end

    always_comb begin
        col_a     = {1'b0, cur.column};
        row_a     = {1'b0, cur.row};
        mid_valid = 1'b0;
        mid       = '{op: OP_GLYPH, column: cur.column, row: cur.row,
                      glyph: char_code, last: 1'b0};
        case (char_code)
            CH_NEWLINE: begin
                col_a = 9'd0;
                row_a = {1'b0, cur.row} + 8'd1;
            end
            CH_BACKSPACE: begin
                if (cur.column != 8'd0 || cur.row != 7'd0) begin
                    mid_valid = 1'b1;
                    mid   = '{op: OP_CLEAR, column: px, row: py, glyph: 8'd0, last: 1'b0};
                    col_a = {1'b0, px};
                    row_a = {1'b0, py};
                end
            end
            CH_TAB: begin
                col_a = tab_stop[8:0];
            end
            default: begin
                mid_valid = 1'b1;
                col_a     = {1'b0, cur.column} + 9'd1;
            end
        endcase

        if (col_a >= {1'b0, ncol}) begin
            col_w = 9'd0;
            row_w = row_a + 8'd1;
        end else begin
            col_w = col_a;
            row_w = row_a;
        end
        scroll = (row_w >= {1'b0, nrow});
        row_s  = scroll ? {1'b0, nrow - 7'd1} : row_w;

        nxt = '{column: col_w[7:0], row: row_s[6:0]};
    end

    always_comb begin
        cmds    = '0;
        cmds[0] = '{op: OP_ERASE, column: shown.column, row: shown.row,
                    glyph: 8'd0, last: 1'b0};
        idx = 2'd1;
        if (mid_valid) begin
            cmds[idx] = mid;
            idx       = idx + 2'd1;
        end
        if (scroll) begin
            cmds[idx] = '{op: OP_SCROLL, column: 8'd0, row: 7'd0, glyph: 8'd0, last: 1'b0};
            idx       = idx + 2'd1;
        end
        cmds[idx] = '{op: OP_CURSOR, column: nxt.column, row: nxt.row,
                      glyph: 8'd0, last: 1'b1};
        count = (char_code == CH_NUL) ? 3'd0 : {1'b0, idx} + 3'd1;
    end

endmodule

// ----- design/text_console_cursor_control.sv -----
// Text console cursor controller: an accepted item is registered, then its
// 2 to 4 commands (none for a NUL) are loaded into the output buffer and
// leave one per cycle while m_ready is high; items follow back to back.
// A columns/rows write holds s_ready low from the access cycle until the
// remainder unit has refreshed the backspace column.
// Synchronous active-low reset: cursor and shown cell at 0,0, geometry 80 x 30.
`timescale 1ns / 1ps

module text_console_cursor_control #(
    parameter int unsigned TAB_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_op,
    output logic [7:0]  m_column,
    output logic [6:0]  m_row,
    output logic [7:0]  m_glyph,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcc_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg;
    logic [7:0]  columns_reg;
    logic [6:0]  rows_reg;
    logic [7:0]  ncol;
    logic [6:0]  nrow;
    pos_t        cur_reg, shown_reg;
    logic [7:0]  bs_col_reg;
    logic        start_reg;
    logic        cfg_wr;
    logic        blocked;
    logic        consume;
    logic        load;
    cmd_t [MAX_CMDS-1:0] buf_reg, buf_next;
    logic [2:0]  cnt_reg, cnt_next;
    cmd_t [MAX_CMDS-1:0] step_cmds;
    logic [2:0]  step_count;
    pos_t        step_nxt;
    mod_stat_t   mod_stat;
    logic [7:0]  mod_rem;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign ncol   = (columns_reg == 8'd0) ? 8'd1 : columns_reg;
    assign nrow   = (rows_reg == 7'd0) ? 7'd1 : rows_reg;

    always_comb begin
        case (paddr[2])
            REG_COLUMNS: prdata = {24'd0, columns_reg};
            REG_ROWS:    prdata = {25'd0, rows_reg};
            default:     prdata = 32'd0;
        endcase
    end

    tcc_step #(.TAB_WIDTH(TAB_WIDTH)) u_step (
        .char_code (in_char_reg),
        .cur       (cur_reg),
        .shown     (shown_reg),
        .bs_column (bs_col_reg),
        .ncol      (ncol),
        .nrow      (nrow),
        .cmds      (step_cmds),
        .count     (step_count),
        .nxt       (step_nxt)
    );

    // backspace column (col-1) % columns, refreshed after a geometry change
    tcc_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (cur_reg.column - 8'd1),
        .divisor  (ncol),
        .status   (mod_stat),
        .rem      (mod_rem)
    );

    assign blocked = cfg_wr | start_reg | mod_stat.busy | mod_stat.done;
    assign consume = in_valid_reg & ~blocked &
                     ((cnt_reg == 3'd0) | ((cnt_reg == 3'd1) & m_ready));
    assign load    = consume & (step_count != 3'd0);
    assign s_ready = ~blocked & (~in_valid_reg | consume);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = step_cmds;
            cnt_next = step_count;
        end else if (m_valid && m_ready) begin
            for (int i = 0; i < MAX_CMDS - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 3'd0;
            start_reg    <= 1'b0;
            columns_reg  <= COLUMNS_RESET;
            rows_reg     <= ROWS_RESET;
            cur_reg      <= '0;
            shown_reg    <= '0;
            bs_col_reg   <= 8'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            start_reg    <= cfg_wr;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_COLUMNS: columns_reg <= pwdata[7:0];
                    REG_ROWS:    rows_reg    <= pwdata[6:0];
                    default:     ;
                endcase
            end
            if (load) begin
                cur_reg    <= step_nxt;
                shown_reg  <= step_nxt;
                // new column is in range, so no wrap on the next backspace
                bs_col_reg <= step_nxt.column - 8'd1;
            end else if (mod_stat.done) begin
                bs_col_reg <= mod_rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
        end
        buf_reg <= buf_next;
    end

    assign m_valid  = (cnt_reg != 3'd0);
    assign m_op     = buf_reg[0].op;
    assign m_column = buf_reg[0].column;
    assign m_row    = buf_reg[0].row;
    assign m_glyph  = buf_reg[0].glyph;
    assign m_last   = buf_reg[0].last;

`ifndef SYNTHESIS
    a_first_is_erase: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_op == OP_ERASE && m_valid))
        else $error("item did not start with a cursor erase");

    a_last_is_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_op == OP_CURSOR))
        else $error("last command of an item is not a cursor draw");

    a_hold_during_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_stat.busy |-> !s_ready)
        else $error("item taken while remainder unit busy");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(MAX_CMDS))
        else $error("command count overflow");
`endif

endmodule
